@@ hw/rtl/falt_pkg.sv @@
// ----------------------------------------------------------------------------
// falt_pkg
// Shared types and constants of the failed-attempt lockout table.
// ----------------------------------------------------------------------------
package falt_pkg;

  localparam int unsigned AddrW    = 32;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CfgAttemptLimit = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgWindowMs     = 8'd1;

  localparam logic [CountW-1:0] LimitReset  = 8'd5;
  localparam logic [TimeW-1:0]  WindowReset = 32'd300000;
  localparam logic [CountW-1:0] CountMax    = 8'hFF;
  localparam logic [CountW-1:0] CountOne    = 8'd1;

  localparam logic ActAttempt = 1'b0;
  localparam logic ActClear   = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StMatch,
    StScan,
    StUpdate
  } falt_state_e;

  typedef struct packed {
    logic load;
    logic match;
    logic scan;
    logic update;
  } falt_cmd_t;

  typedef struct packed {
    logic clear;
    logic hit;
    logic free;
    logic scan_last;
  } falt_sts_t;

endpackage

@@ hw/rtl/falt_if.sv @@
// ----------------------------------------------------------------------------
// falt_if
// Request, response and configuration channels of the lockout table.
// ----------------------------------------------------------------------------
interface falt_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [falt_pkg::AddrW-1:0]   client_address;
  logic [falt_pkg::TimeW-1:0]   now_ms;

  modport source (output valid, action, client_address, now_ms, input ready);
  modport sink   (input valid, action, client_address, now_ms, output ready);
endinterface

interface falt_rsp_if;
  logic valid;
  logic ready;
  logic allowed;

  modport source (output valid, allowed, input ready);
  modport sink   (input valid, allowed, output ready);
endinterface

interface falt_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [falt_pkg::CfgIdxW-1:0]  index;
  logic [falt_pkg::CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/failed_attempt_lockout_table.sv @@
// A request is taken only once the previous result is issued; it is matched,
// then its entry is updated on a clear, a hit or a free entry, while a miss
// on a full table first scans all entries for the oldest one through the
// shared time read port. The update waits while the output is stalled.
// Reset: empties every entry, restores attempt_limit 5 and window_ms 300000.
// ----------------------------------------------------------------------------
// failed_attempt_lockout_table
// Per-source failed-attempt counter with time window and lockout limit.
// ----------------------------------------------------------------------------
module failed_attempt_lockout_table #(
  parameter int unsigned ENTRIES = 3
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  falt_req_if.sink   req_i,
  falt_rsp_if.source rsp_o,
  falt_cfg_if.sink   cfg_i
);

  falt_pkg::falt_cmd_t cmd;
  falt_pkg::falt_sts_t sts;

  assign cfg_i.ready = 1'b1;

  falt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  falt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .action_i         (req_i.action),
    .client_address_i (req_i.client_address),
    .now_ms_i         (req_i.now_ms),
    .cfg_we_i         (cfg_i.valid),
    .cfg_index_i      (cfg_i.index),
    .cfg_data_i       (cfg_i.data),
    .allowed_o        (rsp_o.allowed)
  );

endmodule

@@ hw/rtl/falt_ctrl.sv @@
// ----------------------------------------------------------------------------
// falt_ctrl
// Sequencer: accept a request, match, scan for the oldest entry on a full-table miss, update.
// ----------------------------------------------------------------------------
module falt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  falt_pkg::falt_sts_t sts_i,
  output falt_pkg::falt_cmd_t cmd_o
);

  falt_pkg::falt_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= falt_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      falt_pkg::StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = falt_pkg::StMatch;
        end
      end
      falt_pkg::StMatch: begin
        cmd_o.match = 1'b1;
        if (sts_i.clear || sts_i.hit || sts_i.free) begin
          state_d = falt_pkg::StUpdate;
        end else begin
          state_d = falt_pkg::StScan;
        end
      end
      falt_pkg::StScan: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = falt_pkg::StUpdate;
        end
      end
      falt_pkg::StUpdate: begin
        if (out_free) begin
          cmd_o.update = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = falt_pkg::StIdle;
        end
      end
      default: begin
        state_d = falt_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/falt_dp.sv @@
// ----------------------------------------------------------------------------
// falt_dp
// Entry table, configuration registers, lookup and count update.
// ----------------------------------------------------------------------------
module falt_dp #(
  parameter int unsigned ENTRIES = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  falt_pkg::falt_cmd_t           cmd_i,
  output falt_pkg::falt_sts_t           sts_o,
  input  logic                          action_i,
  input  logic [falt_pkg::AddrW-1:0]    client_address_i,
  input  logic [falt_pkg::TimeW-1:0]    now_ms_i,
  input  logic                          cfg_we_i,
  input  logic [falt_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [falt_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          allowed_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(ENTRIES - 1);

  logic [falt_pkg::AddrW-1:0]  entry_address_q [ENTRIES];
  logic [falt_pkg::CountW-1:0] entry_count_q   [ENTRIES];
  logic [falt_pkg::TimeW-1:0]  entry_time_q    [ENTRIES];

  logic [falt_pkg::CountW-1:0] limit_q;
  logic [falt_pkg::TimeW-1:0]  window_q;

  logic                        act_q;
  logic [falt_pkg::AddrW-1:0]  addr_q;
  logic [falt_pkg::TimeW-1:0]  now_q;
  logic                        hit_q, free_q;
  logic [IdxW-1:0]             hit_idx_q, free_idx_q, best_idx_q, scan_idx_q;
  logic [falt_pkg::TimeW-1:0]  best_time_q;
  logic                        allowed_q;

  logic                        hit_d, free_d;
  logic [IdxW-1:0]             hit_idx_d, free_idx_d;
  logic [IdxW-1:0]             upd_idx, rd_idx;
  logic [falt_pkg::TimeW-1:0]  rd_time, elapsed;
  logic [falt_pkg::CountW-1:0] rd_count, new_count;

  always_comb begin
    hit_d      = 1'b0;
    free_d     = 1'b0;
    hit_idx_d  = '0;
    free_idx_d = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (entry_address_q[i] == addr_q) begin
        hit_d     = 1'b1;
        hit_idx_d = IdxW'(i);
      end
      if (entry_address_q[i] == '0) begin
        free_d     = 1'b1;
        free_idx_d = IdxW'(i);
      end
    end
  end

  assign sts_o.clear     = (act_q == falt_pkg::ActClear);
  assign sts_o.hit       = hit_d;
  assign sts_o.free      = free_d;
  assign sts_o.scan_last = (scan_idx_q == LastIdx);

  assign upd_idx   = hit_q ? hit_idx_q : (free_q ? free_idx_q : best_idx_q);
  assign rd_idx    = cmd_i.scan ? scan_idx_q : upd_idx;
  assign rd_time   = entry_time_q[rd_idx];
  assign rd_count  = entry_count_q[upd_idx];
  assign elapsed   = now_q - rd_time;

  always_comb begin
    if (elapsed > window_q) begin
      new_count = falt_pkg::CountOne;
    end else if (rd_count == falt_pkg::CountMax) begin
      new_count = falt_pkg::CountMax;
    end else begin
      new_count = rd_count + falt_pkg::CountOne;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= falt_pkg::LimitReset;
      window_q <= falt_pkg::WindowReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        falt_pkg::CfgAttemptLimit: limit_q  <= cfg_data_i[falt_pkg::CountW-1:0];
        falt_pkg::CfgWindowMs:     window_q <= cfg_data_i[falt_pkg::TimeW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q  <= action_i;
      addr_q <= client_address_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.match) begin
      hit_q       <= hit_d;
      free_q      <= free_d;
      hit_idx_q   <= hit_idx_d;
      free_idx_q  <= free_idx_d;
      best_idx_q  <= '0;
      best_time_q <= entry_time_q[0];
      scan_idx_q  <= '0;
    end
    if (cmd_i.scan) begin
      if (rd_time < best_time_q) begin
        best_idx_q  <= scan_idx_q;
        best_time_q <= rd_time;
      end
      if (scan_idx_q != LastIdx) begin
        scan_idx_q <= scan_idx_q + 1'b1;
      end
    end
    if (cmd_i.update) begin
      allowed_q <= (act_q == falt_pkg::ActClear) || !hit_q || (new_count < limit_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        entry_address_q[i] <= '0;
        entry_count_q[i]   <= '0;
        entry_time_q[i]    <= '0;
      end
    end else if (cmd_i.update) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (upd_idx == IdxW'(i)) begin
          if (act_q == falt_pkg::ActClear) begin
            if (hit_q) begin
              entry_address_q[i] <= '0;
              entry_count_q[i]   <= '0;
              entry_time_q[i]    <= '0;
            end
          end else if (hit_q) begin
            entry_count_q[i] <= new_count;
            entry_time_q[i]  <= now_q;
          end else begin
            entry_address_q[i] <= addr_q;
            entry_count_q[i]   <= falt_pkg::CountOne;
            entry_time_q[i]    <= now_q;
          end
        end
      end
    end
  end

  assign allowed_o = allowed_q;

endmodule

@@ hw/rtl/falt_checker.sv @@
// ----------------------------------------------------------------------------
// falt_checker
// Port-level checks of the lockout table, bound to the top level.
// ----------------------------------------------------------------------------
module falt_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic allowed_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(allowed_i))
    else $error("response dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("request taken while previous one in flight");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !$rose(out_valid_i))
    else $error("result appeared one cycle after request");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result raised without a request in flight");

endmodule

bind failed_attempt_lockout_table falt_checker u_falt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (req_i.valid),
  .in_ready_i  (req_i.ready),
  .out_valid_i (rsp_o.valid),
  .out_ready_i (rsp_o.ready),
  .allowed_i   (rsp_o.allowed)
);
